>>> sv/amu_pkg.sv
package amu_pkg;

	// Moment store geometry; slot is the low bits of the parameter index
	localparam int unsigned NUM_PARAMS = 4096;
	localparam int unsigned SLOT_W     = $clog2(NUM_PARAMS);

	localparam int unsigned IDX_W     = 12;
	localparam int unsigned CFG_W     = 24;
	localparam int unsigned CFG_IDX_W = 8;

	// Bit steps of the three long iterations
	localparam int unsigned DIV_A_STEPS = 56;
	localparam int unsigned SQRT_STEPS  = 40;
	localparam int unsigned DIV_C_STEPS = 79;

	localparam logic [CFG_W-1:0] RST_BETA_ONE      = 24'd15099494;
	localparam logic [CFG_W-1:0] RST_BETA_TWO      = 24'd16760439;
	localparam logic [CFG_W-1:0] RST_LEARNING_RATE = 24'd16777;
	localparam logic [CFG_W-1:0] RST_EPSILON       = 24'd1;

	localparam logic [24:0] ONE_Q24 = 25'h100_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BETA_ONE      = 8'd0,
		REG_BETA_TWO      = 8'd1,
		REG_LEARNING_RATE = 8'd2,
		REG_EPSILON       = 8'd3
	} amu_reg_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic signed [31:0] w;
		logic neg;
	} amu_tag_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic signed [31:0] w;
		logic signed [31:0] mn;
		logic [31:0] vn;
		logic [24:0] d1;
		logic [24:0] d2;
	} amu_div_in_t;

	typedef struct packed {
		amu_tag_t tag;
		logic [56:0] q;
		logic den_zero;
	} amu_div_out_t;

	// Two parallel dividers; numerator and quotient share one shift register
	typedef struct packed {
		amu_tag_t tag;
		logic [55:0] nq1;
		logic [24:0] r1;
		logic [24:0] d1;
		logic [55:0] nq2;
		logic [24:0] r2;
		logic [24:0] d2;
	} amu_sa_t;

	typedef struct packed {
		amu_tag_t tag;
		logic [55:0] mhat;
		logic [55:0] rad;
		logic [41:0] rem;
		logic [39:0] root;
	} amu_sb_t;

	typedef struct packed {
		amu_tag_t tag;
		logic [78:0] nq;
		logic [40:0] rem;
		logic [40:0] den;
		logic den_zero;
		logic mhat_zero;
	} amu_sc_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic signed [31:0] w;
		logic [24:0] d1;
		logic [24:0] d2;
	} amu_carry_t;

endpackage

>>> sv/amu_if.sv
interface amu_in_if;
	logic valid;
	logic ready;
	logic [amu_pkg::IDX_W-1:0] param_index;
	logic signed [31:0] gradient;
	logic signed [31:0] weight_in;
	logic [23:0] beta_one_power;
	logic [23:0] beta_two_power;

	modport source (output valid, param_index, gradient, weight_in, beta_one_power,
		beta_two_power, input ready);
	modport sink (input valid, param_index, gradient, weight_in, beta_one_power,
		beta_two_power, output ready);
endinterface

interface amu_out_if;
	logic valid;
	logic ready;
	logic [amu_pkg::IDX_W-1:0] index_out;
	logic signed [31:0] weight_out;
	logic saturated;

	modport source (output valid, index_out, weight_out, saturated, input ready);
	modport sink (input valid, index_out, weight_out, saturated, output ready);
endinterface

interface amu_cfg_if;
	logic valid;
	logic ready;
	logic [amu_pkg::CFG_IDX_W-1:0] index;
	logic [amu_pkg::CFG_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> sv/amu_root_div.sv
module amu_root_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic [23:0]          eps,
	input  logic                 in_valid,
	input  amu_pkg::amu_div_in_t in_data,
	output logic                 out_valid,
	output amu_pkg::amu_div_out_t out_data
);

	logic             va_s [amu_pkg::DIV_A_STEPS];
	amu_pkg::amu_sa_t sa_s [amu_pkg::DIV_A_STEPS];
	logic             vb_s [amu_pkg::SQRT_STEPS];
	amu_pkg::amu_sb_t sb_s [amu_pkg::SQRT_STEPS];
	logic             vd_s;
	amu_pkg::amu_sc_t sd_s;
	logic             vc_s [amu_pkg::DIV_C_STEPS];
	amu_pkg::amu_sc_t sc_s [amu_pkg::DIV_C_STEPS];

	amu_pkg::amu_sc_t d_nxt;
	logic [40:0]      den;
	amu_pkg::amu_sc_t c_last;

	// mhat = |m| / d1 and vhat = v / d2, one quotient bit per stage
	for (genvar k = 0; k < amu_pkg::DIV_A_STEPS; k++) begin : g_a
		amu_pkg::amu_sa_t src;
		amu_pkg::amu_sa_t nxt;
		logic             src_v;
		logic [25:0]      t1;
		logic [25:0]      t2;
		logic             ge1;
		logic             ge2;

		if (k == 0) begin : g_head
			assign src_v = in_valid;
			always_comb begin
				src.tag.idx = in_data.idx;
				src.tag.w   = in_data.w;
				src.tag.neg = in_data.mn[31];
				src.nq1 = {(in_data.mn[31] ? 32'(-in_data.mn) : 32'(in_data.mn)), 24'd0};
				src.r1  = '0;
				src.d1  = in_data.d1;
				src.nq2 = {in_data.vn, 24'd0};
				src.r2  = '0;
				src.d2  = in_data.d2;
			end
		end else begin : g_body
			assign src_v = va_s[k-1];
			assign src   = sa_s[k-1];
		end

		always_comb begin
			nxt = src;
			t1  = {src.r1, src.nq1[55]};
			ge1 = t1 >= {1'b0, src.d1};
			nxt.r1  = ge1 ? 25'(t1 - {1'b0, src.d1}) : t1[24:0];
			nxt.nq1 = {src.nq1[54:0], ge1};
			t2  = {src.r2, src.nq2[55]};
			ge2 = t2 >= {1'b0, src.d2};
			nxt.r2  = ge2 ? 25'(t2 - {1'b0, src.d2}) : t2[24:0];
			nxt.nq2 = {src.nq2[54:0], ge2};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				va_s[k] <= 1'b0;
			end else if (adv) begin
				va_s[k] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sa_s[k] <= nxt;
			end
		end
	end

	// Root of vhat * 2^24, one root bit per stage
	for (genvar k = 0; k < amu_pkg::SQRT_STEPS; k++) begin : g_b
		amu_pkg::amu_sb_t src;
		amu_pkg::amu_sb_t nxt;
		logic             src_v;
		logic [43:0]      trial;
		logic [43:0]      test;
		logic             ge;

		if (k == 0) begin : g_head
			assign src_v = va_s[amu_pkg::DIV_A_STEPS-1];
			always_comb begin
				src.tag  = sa_s[amu_pkg::DIV_A_STEPS-1].tag;
				src.mhat = sa_s[amu_pkg::DIV_A_STEPS-1].nq1;
				src.rad  = sa_s[amu_pkg::DIV_A_STEPS-1].nq2;
				src.rem  = '0;
				src.root = '0;
			end
		end else begin : g_body
			assign src_v = vb_s[k-1];
			assign src   = sb_s[k-1];
		end

		always_comb begin
			nxt   = src;
			trial = {src.rem, src.rad[55:54]};
			test  = {2'b00, src.root, 2'b01};
			ge    = trial >= test;
			nxt.rem  = ge ? 42'(trial - test) : trial[41:0];
			nxt.root = {src.root[38:0], ge};
			nxt.rad  = {src.rad[53:0], 2'b00};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vb_s[k] <= 1'b0;
			end else if (adv) begin
				vb_s[k] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sb_s[k] <= nxt;
			end
		end
	end

	// Add epsilon to the root and set up the last division
	assign den = 41'(sb_s[amu_pkg::SQRT_STEPS-1].root) + 41'(eps);

	always_comb begin
		d_nxt.tag       = sb_s[amu_pkg::SQRT_STEPS-1].tag;
		d_nxt.nq        = {sb_s[amu_pkg::SQRT_STEPS-1].mhat[54:0], 24'd0};
		d_nxt.rem       = '0;
		d_nxt.den       = den;
		d_nxt.den_zero  = den == '0;
		d_nxt.mhat_zero = sb_s[amu_pkg::SQRT_STEPS-1].mhat == '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vd_s <= 1'b0;
		end else if (adv) begin
			vd_s <= vb_s[amu_pkg::SQRT_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s <= d_nxt;
		end
	end

	// q = mhat * 2^24 / den, one quotient bit per stage
	for (genvar k = 0; k < amu_pkg::DIV_C_STEPS; k++) begin : g_c
		amu_pkg::amu_sc_t src;
		amu_pkg::amu_sc_t nxt;
		logic             src_v;
		logic [41:0]      trial;
		logic             ge;

		if (k == 0) begin : g_head
			assign src_v = vd_s;
			assign src   = sd_s;
		end else begin : g_body
			assign src_v = vc_s[k-1];
			assign src   = sc_s[k-1];
		end

		always_comb begin
			nxt   = src;
			trial = {src.rem, src.nq[78]};
			ge    = trial >= {1'b0, src.den};
			nxt.rem = ge ? 41'(trial - {1'b0, src.den}) : trial[40:0];
			nxt.nq  = {src.nq[77:0], ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vc_s[k] <= 1'b0;
			end else if (adv) begin
				vc_s[k] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sc_s[k] <= nxt;
			end
		end
	end

	// Cap the quotient at 2^56; a zero divisor gives the cap unless mhat is zero
	assign c_last    = sc_s[amu_pkg::DIV_C_STEPS-1];
	assign out_valid = vc_s[amu_pkg::DIV_C_STEPS-1];

	always_comb begin
		out_data.tag      = c_last.tag;
		out_data.den_zero = c_last.den_zero;
		if (c_last.den_zero) begin
			out_data.q = c_last.mhat_zero ? 57'd0 : {1'b1, 56'd0};
		end else if (c_last.nq[78:56] != '0) begin
			out_data.q = {1'b1, 56'd0};
		end else begin
			out_data.q = c_last.nq[56:0];
		end
	end

endmodule

>>> sv/adam_moment_update_unit.sv
// Channel   Dir  Payload                                                      Handshake
// item      in   param_index, gradient, weight_in, beta_one_power, beta_two_power  valid/ready
// result    out  index_out, weight_out, saturated                             valid/ready
// cfg       in   index, data (beta_one, beta_two, learning_rate, epsilon)     valid/ready
//
// One request per cycle sustained while result is not stalled; the bit-serial core
// has 56 divider stages, 40 root stages and 79 divider stages.
// After reset the moment stores are swept to zero, one entry per cycle;
// item.ready stays low until the sweep ends. Config writes are always taken.
// A stall on result freezes every stage at once; nothing is dropped or repeated.
module adam_moment_update_unit (
	input  logic       clk,
	input  logic       arst_n,
	amu_in_if.sink     item,
	amu_out_if.source  result,
	amu_cfg_if.sink    cfg
);

	// Configuration registers
	logic [23:0] beta_one_q;
	logic [23:0] beta_two_q;
	logic [23:0] learning_rate_q;
	logic [23:0] epsilon_q;
	logic [24:0] om_b1;
	logic [24:0] om_b2;

	// Sweep and global advance
	logic [amu_pkg::SLOT_W:0] clr_cnt_q;
	logic                     clearing;
	logic                     adv;
	logic                     acc_in;

	// Front stages
	logic                v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	amu_pkg::amu_carry_t c_s1, c_s2, c_s3, c_s4, c_s5, c_s6;
	logic signed [31:0]  g_s1;
	logic [31:0]         ug_s2;
	logic signed [56:0]  pg_s2, pg_s3, pg_s4, pg_s5, pg_s6;
	logic [63:0]         gg_s3;
	logic [63:0]         gg_rnd;
	logic [31:0]         g2_s4;
	logic [56:0]         pv_s5, pv_s6;

	// Moment stores, read port register and write-back bypass
	logic [31:0] mem_m [amu_pkg::NUM_PARAMS];
	logic [31:0] mem_v [amu_pkg::NUM_PARAMS];
	logic [31:0] rd_m_q;
	logic [31:0] rd_v_q;
	logic        wb_vld_q;
	logic [amu_pkg::SLOT_W-1:0] wb_slot_q;
	logic [31:0] wb_m_q;
	logic [31:0] wb_sq_q;
	logic [amu_pkg::SLOT_W-1:0] slot_s5;
	logic [amu_pkg::SLOT_W-1:0] slot_s6;

	// Moment update
	logic               fwd_hit;
	logic signed [31:0] m_old;
	logic [31:0]        v_old;
	logic signed [56:0] prod_m;
	logic signed [57:0] acc_m;
	logic [55:0]        prod_v;
	logic [57:0]        acc_v;
	logic [31:0]        m_new;
	logic [31:0]        v_new;
	amu_pkg::amu_div_in_t dv_s7;

	// Divider chain and tail
	logic                  dq_valid;
	amu_pkg::amu_div_out_t dq;
	amu_pkg::amu_tag_t     tag_s8;
	logic                  dz_s8;
	logic [56:0]           ph_s8;
	logic [47:0]           pl_s8;
	logic [57:0]           step;
	logic signed [59:0]    res;
	logic                  res_ovf;

	logic                      out_v_q;
	logic [amu_pkg::IDX_W-1:0] out_idx_q;
	logic signed [31:0]        out_w_q;
	logic                      out_sat_q;

	// Config writes; unknown indexes are dropped
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_one_q      <= amu_pkg::RST_BETA_ONE;
			beta_two_q      <= amu_pkg::RST_BETA_TWO;
			learning_rate_q <= amu_pkg::RST_LEARNING_RATE;
			epsilon_q       <= amu_pkg::RST_EPSILON;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				amu_pkg::REG_BETA_ONE:      beta_one_q      <= cfg.data;
				amu_pkg::REG_BETA_TWO:      beta_two_q      <= cfg.data;
				amu_pkg::REG_LEARNING_RATE: learning_rate_q <= cfg.data;
				amu_pkg::REG_EPSILON:       epsilon_q       <= cfg.data;
				default: ;
			endcase
		end
	end

	assign om_b1 = amu_pkg::ONE_Q24 - {1'b0, beta_one_q};
	assign om_b2 = amu_pkg::ONE_Q24 - {1'b0, beta_two_q};

	// Sweep the stores after reset; the top counter bit ends it
	assign clearing = !clr_cnt_q[amu_pkg::SLOT_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (clearing) begin
			clr_cnt_q <= (amu_pkg::SLOT_W+1)'(clr_cnt_q + 1'b1);
		end
	end

	// Whole pipe moves whenever the output register is free or being drained
	assign adv        = !out_v_q || result.ready;
	assign item.ready = adv && !clearing;
	assign acc_in     = item.valid && item.ready;

	// Valid chain for the front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= acc_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// Stage 1: capture request, form the bias-correction denominators
	// Stage 2: |g| and (1 - b1) * g
	// Stage 3: g * g
	// Stage 4: round and clamp g^2
	// Stage 5: (1 - b2) * g^2, issue store read
	always_ff @(posedge clk) begin
		if (adv) begin
			c_s1.idx <= item.param_index;
			c_s1.w   <= item.weight_in;
			c_s1.d1  <= amu_pkg::ONE_Q24 - {1'b0, item.beta_one_power};
			c_s1.d2  <= amu_pkg::ONE_Q24 - {1'b0, item.beta_two_power};
			g_s1     <= item.gradient;

			c_s2  <= c_s1;
			ug_s2 <= g_s1[31] ? 32'(-g_s1) : 32'(g_s1);
			pg_s2 <= $signed({1'b0, om_b1}) * g_s1;

			c_s3  <= c_s2;
			pg_s3 <= pg_s2;
			gg_s3 <= ug_s2 * ug_s2;

			c_s4  <= c_s3;
			pg_s4 <= pg_s3;
			g2_s4 <= (gg_rnd[63:56] != '0) ? 32'hFFFF_FFFF : gg_rnd[55:24];

			c_s5  <= c_s4;
			pg_s5 <= pg_s4;
			pv_s5 <= om_b2 * g2_s4;

			c_s6  <= c_s5;
			pg_s6 <= pg_s5;
			pv_s6 <= pv_s5;
		end
	end

	assign gg_rnd  = gg_s3 + 64'd8388608;
	assign slot_s5 = c_s5.idx[amu_pkg::SLOT_W-1:0];
	assign slot_s6 = c_s6.idx[amu_pkg::SLOT_W-1:0];

	// Stores: sweep writes zero, otherwise stage 6 writes back its new moments
	always_ff @(posedge clk) begin
		if (clearing) begin
			mem_m[clr_cnt_q[amu_pkg::SLOT_W-1:0]] <= '0;
			mem_v[clr_cnt_q[amu_pkg::SLOT_W-1:0]] <= '0;
		end else if (adv && v_s6) begin
			mem_m[slot_s6] <= m_new;
			mem_v[slot_s6] <= v_new;
		end
		if (adv) begin
			rd_m_q <= mem_m[slot_s5];
			rd_v_q <= mem_v[slot_s5];
		end
	end

	// The read for stage 6 misses the write made on the same edge; bypass it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_vld_q <= 1'b0;
		end else if (adv && v_s6) begin
			wb_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s6) begin
			wb_slot_q <= slot_s6;
			wb_m_q    <= m_new;
			wb_sq_q   <= v_new;
		end
	end

	assign fwd_hit = wb_vld_q && (wb_slot_q == slot_s6);
	assign m_old   = fwd_hit ? wb_m_q : rd_m_q;
	assign v_old   = fwd_hit ? wb_sq_q : rd_v_q;

	// Stage 6: m' = round(b1*m + (1-b1)*g), v' = round(b2*v + (1-b2)*g2), clamp both
	assign prod_m = $signed({1'b0, beta_one_q}) * m_old;
	assign acc_m  = 58'(prod_m) + 58'(pg_s6) + 58'sd8388608;
	assign prod_v = beta_two_q * v_old;
	assign acc_v  = 58'(prod_v) + 58'(pv_s6) + 58'd8388608;

	always_comb begin
		if ((acc_m[57:55] == 3'b000) || (acc_m[57:55] == 3'b111)) begin
			m_new = acc_m[55:24];
		end else begin
			m_new = acc_m[57] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end
		v_new = (acc_v[57:56] != 2'b00) ? 32'hFFFF_FFFF : acc_v[55:24];
	end

	// Stage 7: hand the new moments to the divider chain
	always_ff @(posedge clk) begin
		if (adv) begin
			dv_s7.idx <= c_s6.idx;
			dv_s7.w   <= c_s6.w;
			dv_s7.mn  <= m_new;
			dv_s7.vn  <= v_new;
			dv_s7.d1  <= c_s6.d1;
			dv_s7.d2  <= c_s6.d2;
		end
	end

	amu_root_div u_root_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.eps       (epsilon_q),
		.in_valid  (v_s7),
		.in_data   (dv_s7),
		.out_valid (dq_valid),
		.out_data  (dq)
	);

	// Stage 8: split a * q into high and low partial products
	logic v_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s8 <= dq_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s8 <= dq.tag;
			dz_s8  <= dq.den_zero;
			ph_s8  <= learning_rate_q * dq.q[56:24];
			pl_s8  <= learning_rate_q * dq.q[23:0];
		end
	end

	// Output: apply the step against the sign of m', clamp to 32 bits
	assign step = 58'(ph_s8) + 58'(pl_s8[47:24]);

	always_comb begin
		if (tag_s8.neg) begin
			res = 60'(tag_s8.w) + $signed({2'b00, step});
		end else begin
			res = 60'(tag_s8.w) - $signed({2'b00, step});
		end
		res_ovf = (res[59:31] != '0) && (res[59:31] != '1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_idx_q <= tag_s8.idx;
			out_sat_q <= dz_s8 || res_ovf;
			if (res_ovf) begin
				out_w_q <= res[59] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
			end else begin
				out_w_q <= res[31:0];
			end
		end
	end

	assign result.valid      = out_v_q;
	assign result.index_out  = out_idx_q;
	assign result.weight_out = out_w_q;
	assign result.saturated  = out_sat_q;

`ifndef SYNTHESIS
	a_no_intake_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !item.ready)
		else $error("request accepted during store sweep");

	a_no_update_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !v_s6)
		else $error("moment write-back collides with store sweep");

	a_update_held_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s6 && !adv) |=> (v_s6 && $stable(slot_s6) && $stable(wb_slot_q)))
		else $error("moment update stage moved during stall");
`endif

endmodule
